>>> hdl/assert_macros.svh
// Assertion macros shared by the checking code of the height sampler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define GBH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define GBH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gbh_pkg.sv
// Constants and helper functions of the grid bilinear height sampler
package gbh_pkg;

    localparam int GRID_CELLS   = 32;
    localparam int GRID_SIDE    = GRID_CELLS + 1;
    localparam int GRID_ENTRIES = GRID_SIDE * GRID_SIDE;

    // four banks by row and column parity
    localparam int NUM_BANKS  = 4;
    localparam int GRID_HALF  = (GRID_SIDE + 1) / 2;
    localparam int BANK_DEPTH = GRID_HALF * GRID_HALF;
    localparam int BANK_AW    = $clog2(BANK_DEPTH + 1);
    localparam int CELL_W     = $clog2(GRID_SIDE + 1);

    // field widths
    localparam int IDX_W    = 11;
    localparam int HEIGHT_W = 16;
    localparam int COORD_W  = 24;
    localparam int STEP_W   = 24;
    localparam int FRAC_W   = 8;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    // scaled coordinate: 24 fractional bits, fraction taken from bits 23..16
    localparam int PROD_W   = COORD_W + STEP_W + 1;
    localparam int CELL_LSB = 24;
    localparam int FRAC_LSB = CELL_LSB - FRAC_W;

    // row of a write index by reciprocal multiply
    localparam int DIV_SH  = IDX_W + CELL_W + 4;
    localparam int RECIP   = (2 ** DIV_SH + GRID_SIDE - 1) / GRID_SIDE;
    localparam int RECIP_W = DIV_SH + 1;
    localparam int QUOT_W  = IDX_W + RECIP_W;

    // interpolation widths
    localparam int H0_W  = HEIGHT_W + FRAC_W;
    localparam int HM_W  = HEIGHT_W + FRAC_W + 2;
    localparam int R_W   = H0_W + FRAC_W + 2;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [CELL_W-1:0] row,
                                                      input logic [CELL_W-1:0] col);
        logic [BANK_AW:0] acc;
        acc = (BANK_AW + 1)'(row >> 1) * (BANK_AW + 1)'(GRID_HALF)
            + (BANK_AW + 1)'(col >> 1);
        return acc[BANK_AW-1:0];
    endfunction

endpackage

>>> hdl/gbh_if.sv
// Channel interfaces of the grid bilinear height sampler
interface gbh_item_if import gbh_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [IDX_W-1:0]           grid_index;
    logic signed [HEIGHT_W-1:0] height_value;
    logic signed [COORD_W-1:0]  local_x;
    logic signed [COORD_W-1:0]  local_z;

    modport source (output valid, action, grid_index, height_value, local_x, local_z,
                    input ready);
    modport sink (input valid, action, grid_index, height_value, local_x, local_z,
                  output ready);
endinterface

interface gbh_result_if import gbh_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] sampled_height;
    logic                       outside;

    modport source (output valid, sampled_height, outside, input ready);
    modport sink (input valid, sampled_height, outside, output ready);
endinterface

interface gbh_cfg_if import gbh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] inverse_step;

    modport source (output valid, inverse_step, input ready);
    modport sink (input valid, inverse_step, output ready);
endinterface

>>> hdl/gbh_ram.sv
// Generic simple dual-port RAM with registered read
module gbh_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/grid_bilinear_height_sample_top.sv
// Top level of the grid bilinear height sampler
// A query's result passes stage A, stage B, stage C and then the output register, where it is offered.
// Throughput: one item per cycle while results are taken, writes and queries alike; the four parity
// banks deliver all four cell corners in a single read.
// A write lands in its bank from the stage A register, before any later query reads.
// Reset clears the pipeline valids and sets inverse_step to 1.0; the grid stays undefined.
module grid_bilinear_height_sample_top import gbh_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    gbh_cfg_if.sink     cfg,
    gbh_item_if.sink    item,
    gbh_result_if.source result
);

`include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration: one register, always ready
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] inv_step_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_step_reg <= STEP_RESET;
        end
        else if (cfg.valid)
        begin
            inv_step_reg <= cfg.inverse_step;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // Stage A holds products, issues the bank read or write.
    // Stage B holds bank data, stage C holds the x interpolations,
    // then the output register. Each stage advances when the one after
    // has room, so bubbles collapse and a waiting result stalls the
    // stages behind it only as they fill up.
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, out_valid_reg;
    logic a_query_reg;
    logic load_out, go_c, en_c, go_b, en_b, go_a, en_a;

    assign load_out = !out_valid_reg || result.ready;
    assign go_c     = c_valid_reg && load_out;
    assign en_c     = !c_valid_reg || go_c;
    assign go_b     = b_valid_reg && en_c;
    assign en_b     = !b_valid_reg || go_b;
    // a write retires in stage A, a query needs room in stage B
    assign go_a     = a_valid_reg && (!a_query_reg || en_b);
    assign en_a     = !a_valid_reg || go_a;

    assign item.ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= item.valid;
            end
            if (en_b)
            begin
                b_valid_reg <= go_a && a_query_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= go_b;
            end
            if (load_out)
            begin
                out_valid_reg <= go_c;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: scale coordinates, find the row of a write index
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] a_px_reg, a_pz_reg, a_px_next, a_pz_next;
    logic [CELL_W-1:0]        a_row_reg, a_row_next;
    logic [IDX_W-1:0]         a_idx_reg;
    logic [HEIGHT_W-1:0]      a_height_reg;
    logic                     a_wr_ok_reg, a_wr_ok_next;
    logic [QUOT_W-1:0]        quot;

    always_comb
    begin
        a_px_next    = PROD_W'(item.local_x) * PROD_W'(signed'({1'b0, inv_step_reg}));
        a_pz_next    = PROD_W'(item.local_z) * PROD_W'(signed'({1'b0, inv_step_reg}));
        quot         = QUOT_W'(item.grid_index) * QUOT_W'(RECIP);
        a_row_next   = quot[DIV_SH +: CELL_W];
        a_wr_ok_next = 32'(item.grid_index) < 32'(GRID_ENTRIES);
    end

    always_ff @(posedge clk)
    begin
        if (en_a && item.valid)
        begin
            a_query_reg  <= item.action;
            a_px_reg     <= a_px_next;
            a_pz_reg     <= a_pz_next;
            a_row_reg    <= a_row_next;
            a_idx_reg    <= item.grid_index;
            a_height_reg <= item.height_value;
            a_wr_ok_reg  <= a_wr_ok_next;
        end
    end

    // Cell out of range when the scaled value is negative or its floor
    // reaches the grid size.
    function automatic logic coord_outside(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-CELL_LSB-2:0] hi;
        hi = p[PROD_W-2:CELL_LSB];
        return p[PROD_W-1] || (hi >= (PROD_W - CELL_LSB - 1)'(GRID_CELLS));
    endfunction

    logic [CELL_W-1:0]  xi, zi, xi_next, zi_next, w_col;
    logic [FRAC_W-1:0]  tx, tz;
    logic               q_outside;
    logic [IDX_W-1:0]   row_off, col_full;
    logic [BANK_AW-1:0] w_addr;
    logic [1:0]         w_bank;

    logic [NUM_BANKS-1:0]                bank_we;
    logic                                bank_re;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]   bank_raddr;
    logic [NUM_BANKS-1:0][HEIGHT_W-1:0]  bank_rdata;

    always_comb
    begin
        xi        = a_px_reg[CELL_LSB +: CELL_W];
        zi        = a_pz_reg[CELL_LSB +: CELL_W];
        xi_next   = xi + CELL_W'(1);
        zi_next   = zi + CELL_W'(1);
        tx        = a_px_reg[FRAC_LSB +: FRAC_W];
        tz        = a_pz_reg[FRAC_LSB +: FRAC_W];
        q_outside = coord_outside(a_px_reg) || coord_outside(a_pz_reg);

        // column of a write: index minus row times side
        row_off   = IDX_W'(IDX_W'(a_row_reg) * IDX_W'(GRID_SIDE));
        col_full  = a_idx_reg - row_off;
        w_col     = col_full[CELL_W-1:0];
        w_addr    = bank_addr(a_row_reg, w_col);
        w_bank    = {a_row_reg[0], w_col[0]};

        bank_re   = go_a && a_query_reg;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            // bank b holds rows of parity b[1] and columns of parity b[0]
            bank_raddr[b] = bank_addr((zi[0] == b[1]) ? zi : zi_next,
                                      (xi[0] == b[0]) ? xi : xi_next);
            bank_we[b]    = a_valid_reg && !a_query_reg && a_wr_ok_reg
                            && (w_bank == 2'(b));
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        gbh_ram #(
            .WIDTH  (HEIGHT_W),
            .DEPTH  (BANK_DEPTH),
            .ADDR_W (BANK_AW)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (w_addr),
            .wdata (a_height_reg),
            .re    (bank_re),
            .raddr (bank_raddr[g]),
            .rdata (bank_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage B: bank data arrives; interpolate along x
    // ------------------------------------------------------------------
    logic              b_outside_reg, b_xp_reg, b_zp_reg;
    logic [FRAC_W-1:0] b_tx_reg, b_tz_reg;

    always_ff @(posedge clk)
    begin
        if (bank_re)
        begin
            b_outside_reg <= q_outside;
            b_xp_reg      <= xi[0];
            b_zp_reg      <= zi[0];
            b_tx_reg      <= tx;
            b_tz_reg      <= tz;
        end
    end

    logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;
    logic signed [HEIGHT_W:0]   d0, d1;
    logic signed [HM_W-1:0]     m0, m1, txs;
    logic signed [H0_W-1:0]     c_h0_next, c_h1_next;

    always_comb
    begin
        h00 = signed'(bank_rdata[{b_zp_reg, b_xp_reg}]);
        h10 = signed'(bank_rdata[{b_zp_reg, !b_xp_reg}]);
        h01 = signed'(bank_rdata[{!b_zp_reg, b_xp_reg}]);
        h11 = signed'(bank_rdata[{!b_zp_reg, !b_xp_reg}]);
        d0  = (HEIGHT_W + 1)'(h10) - (HEIGHT_W + 1)'(h00);
        d1  = (HEIGHT_W + 1)'(h11) - (HEIGHT_W + 1)'(h01);
        txs = HM_W'(signed'({1'b0, b_tx_reg}));
        m0  = HM_W'(signed'({h00, {FRAC_W{1'b0}}})) + HM_W'(d0) * txs;
        m1  = HM_W'(signed'({h01, {FRAC_W{1'b0}}})) + HM_W'(d1) * txs;
        c_h0_next = H0_W'(m0);
        c_h1_next = H0_W'(m1);
    end

    // ------------------------------------------------------------------
    // Stage C: interpolate along z, floor to Q8.8
    // ------------------------------------------------------------------
    logic signed [H0_W-1:0] c_h0_reg, c_h1_reg;
    logic [FRAC_W-1:0]      c_tz_reg;
    logic                   c_outside_reg;

    always_ff @(posedge clk)
    begin
        if (go_b)
        begin
            c_h0_reg      <= c_h0_next;
            c_h1_reg      <= c_h1_next;
            c_tz_reg      <= b_tz_reg;
            c_outside_reg <= b_outside_reg;
        end
    end

    logic signed [H0_W:0]       dz;
    logic signed [R_W-1:0]      r_full;
    logic signed [HEIGHT_W-1:0] height_next;

    always_comb
    begin
        dz     = (H0_W + 1)'(c_h1_reg) - (H0_W + 1)'(c_h0_reg);
        r_full = R_W'(signed'({c_h0_reg, {FRAC_W{1'b0}}}))
               + R_W'(dz) * R_W'(signed'({1'b0, c_tz_reg}));
        // dropping 16 low bits of two's complement floors toward minus infinity
        height_next = c_outside_reg ? '0
                                    : signed'(r_full[2*FRAC_W +: HEIGHT_W]);
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] height_reg;
    logic                       outside_reg;

    always_ff @(posedge clk)
    begin
        if (go_c)
        begin
            height_reg  <= height_next;
            outside_reg <= c_outside_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.sampled_height = height_reg;
    assign result.outside        = outside_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // writes retire in stage A, so a bank is never read and written together
    `GBH_ASSERT_IMP(a_rw_excl, (|bank_we), !bank_re, "bank write collides with read")
    // a stalled stage B must keep the bank data it was given
    `GBH_ASSERT_NEXT(a_bank_hold, b_valid_reg && !go_b, $stable(bank_rdata),
                     "bank data lost while stage B stalls")
    // a query transfer always lands in stage A
    `GBH_ASSERT_NEXT(a_query_in, item.valid && item.ready && item.action,
                     a_valid_reg && a_query_reg, "query transfer not captured")
    // an outside query carries a zero height
    `GBH_ASSERT_IMP(a_out_zero, result.valid && result.outside,
                    result.sampled_height == '0, "outside result with non-zero height")

endmodule
